// ===== hw/rtl/lz4d_pkg.sv =====
// Shared types and default sizes for the LZ4 block decoder.
package lz4d_pkg;

    localparam int HISTORY_DEPTH_DEF = 65536;
    localparam int SIZE_BITS_DEF     = 24;

    // Width of the reported byte count, fixed by the result format.
    localparam int TOTAL_W = 24;

    // Result queue between the decoder core and the output channel.
    localparam int OUT_FIFO_DEPTH = 3;
    localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
    localparam int OUT_LVL_W      = $clog2(OUT_FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               out_valid;
        logic [2:0]         status;
        logic [TOTAL_W-1:0] total_size;
        logic               copy_pending;
    } t_out_item;

endpackage

// ===== hw/rtl/lz4d_stream_if.sv =====
// Valid/ready stream channel carrying one payload per beat.
interface lz4d_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/lz4d_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
module lz4d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the entry being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/lz4d_out_fifo.sv =====
// Small result queue that decouples the decoder core from the output channel.
module lz4d_out_fifo
    import lz4d_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_out_item             i_push_item,
    output logic [OUT_LVL_W-1:0]  o_level,
    lz4d_stream_if.source         o_res
);
    t_out_item             r_mem [OUT_FIFO_DEPTH];
    logic [OUT_PTR_W-1:0]  r_wr_ptr;
    logic [OUT_PTR_W-1:0]  r_rd_ptr;
    logic [OUT_LVL_W-1:0]  r_level;
    logic [OUT_PTR_W-1:0]  n_wr_ptr;
    logic [OUT_PTR_W-1:0]  n_rd_ptr;
    logic [OUT_LVL_W-1:0]  n_level;
    logic                  pop;

    assign pop = o_res.valid && o_res.ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == OUT_PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == OUT_PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, pop})
            2'b10:   n_level = r_level + 1'b1;
            2'b01:   n_level = r_level - 1'b1;
            default: n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    assign o_res.valid   = (r_level != '0);
    assign o_res.payload = r_mem[r_rd_ptr];
    assign o_level       = r_level;
endmodule

// ===== hw/rtl/lz4_block_decoder.sv =====
// LZ4 block decoder: token parser, history RAM and result queue.
// The result of an accepted beat passes the second-stage register and the result queue
// before it is offered on o_res. Throughput: one beat per cycle (byte, pull or start)
// while the queue has room; each beat reads and writes the history RAM at most once, and a literal
// or pulled byte is written in the cycle after its beat is taken. Reset clears the parser,
// counters and result queue; the history RAM is not cleared and needs no clearing pass.
module lz4_block_decoder
    import lz4d_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int SIZE_BITS     = SIZE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lz4d_stream_if.sink   i_cmd,
    lz4d_stream_if.source o_res
);
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int SB = SIZE_BITS;

    // Commands.
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_PULL  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BUSY     = 3'd1;
    localparam logic [2:0] ST_DONE     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_BAD_OFF  = 3'd4;
    localparam logic [2:0] ST_END_RULE = 3'd5;
    localparam logic [2:0] ST_TRUNC    = 3'd6;
    localparam logic [2:0] ST_OVERFLOW = 3'd7;

    // Parse phases.
    localparam logic [2:0] PH_TOKEN  = 3'd0;
    localparam logic [2:0] PH_LITEXT = 3'd1;
    localparam logic [2:0] PH_LIT    = 3'd2;
    localparam logic [2:0] PH_OFFLO  = 3'd3;
    localparam logic [2:0] PH_OFFHI  = 3'd4;
    localparam logic [2:0] PH_MEXT   = 3'd5;

    // Format constants.
    localparam logic [3:0] LIT_EXT       = 4'hF;
    localparam logic [7:0] EXT_MORE      = 8'hFF;
    localparam int         MIN_MATCH     = 4;
    localparam int         MATCH_EXT_LEN = 19;
    localparam int         MIN_LAST_LIT  = 5;
    localparam int         END_GAP       = 12;

    typedef logic [SB-1:0] t_cnt;

    // One accepted beat in the second stage; a pull also waits here for its history read.
    typedef struct packed {
        logic [2:0]         status;
        logic               out_valid;
        logic [7:0]         lit_byte;
        logic               from_mem;
        logic               fwd;
        logic [TOTAL_W-1:0] total_size;
        logic               copy_pending;
        logic [AW-1:0]      wr_addr;
    } t_s1;

    // End rules for a block that closes after a literal run.
    function automatic logic [2:0] f_end_code(t_cnt oc, t_cnt llr, t_cnt lms);
        logic [2:0] code;
        t_cnt       gap;
        gap  = oc - lms;
        code = ST_DONE;
        if (oc >= t_cnt'(MIN_LAST_LIT) && llr < t_cnt'(MIN_LAST_LIT)) begin
            code = ST_END_RULE;
        end else if (oc > t_cnt'(END_GAP) && gap < t_cnt'(END_GAP)) begin
            code = ST_END_RULE;
        end
        return code;
    endfunction

    // Parser state.
    logic [2:0]  r_phase,  n_phase;
    t_cnt        r_lit,    n_lit;
    t_cnt        r_ml,     n_ml;
    t_cnt        r_mb,     n_mb;
    logic [15:0] r_off,    n_off;
    t_cnt        r_oc,     n_oc;
    t_cnt        r_lms,    n_lms;
    t_cnt        r_llr,    n_llr;
    logic        r_fin,    n_fin;
    logic        r_first,  n_first;
    logic [2:0]  r_end,    n_end;
    logic [AW-1:0] r_wptr, n_wptr;

    // Second stage and forwarding.
    logic        r_s1_valid;
    t_s1         r_s1;
    t_s1         n_s1;
    logic [7:0]  r_fwd_data;
    logic [7:0]  s1_byte;
    logic [7:0]  ram_rdata;
    logic        ram_we;

    logic [OUT_LVL_W-1:0] fifo_level;
    t_out_item            push_item;

    logic        acc;
    logic [1:0]  cmd;
    logic [7:0]  b;
    logic        last;

    logic [SB:0]   fit_arg;
    logic [SB+1:0] fit_sum;
    logic          fits;
    logic [15:0]   off_new;
    logic          bad_off;
    logic [AW:0]   off_w;
    logic [AW:0]   wp_w;
    logic [AW:0]   src_w;
    logic [AW-1:0] src;
    logic [AW-1:0] wptr_inc;

    logic        v_fin;
    logic [2:0]  v_code;
    logic [2:0]  v_st;
    logic        v_emit;
    logic        v_from_mem;

    assign cmd  = i_cmd.payload.command;
    assign b    = i_cmd.payload.data_byte;
    assign last = i_cmd.payload.last_byte;

    // The stage register always drains into the queue, so an accepted beat
    // only needs a free queue slot in the cycle after it is accepted.
    assign i_cmd.ready = (3'(fifo_level) + 3'(r_s1_valid)) < 3'(OUT_FIFO_DEPTH);
    assign acc         = i_cmd.valid && i_cmd.ready;

    // One shared overflow check. The length under test depends on the phase:
    // a new literal count, an extended literal count, or a match length.
    always_comb begin
        case (r_phase)
            PH_TOKEN:  fit_arg = (SB+1)'(b[7:4]);
            PH_LITEXT: fit_arg = {1'b0, r_lit} + (SB+1)'(b);
            PH_OFFHI:  fit_arg = {1'b0, r_mb};
            default:   fit_arg = {1'b0, r_mb} + (SB+1)'(b);
        endcase
    end

    assign fit_sum = (SB+2)'(r_oc) + (SB+2)'(fit_arg);
    assign fits    = (fit_sum[SB+1:SB] == 2'b00);

    // Offset checks: zero, beyond the bytes produced so far, or beyond the window.
    assign off_new = {b, r_off[7:0]};
    assign bad_off = (off_new == 16'h0000) || (SB'(off_new) > r_oc) ||
                     (17'(off_new) > 17'(HISTORY_DEPTH));

    // Copy source: the write pointer minus the offset, wrapped inside the window.
    assign off_w    = (AW+1)'(r_off);
    assign wp_w     = {1'b0, r_wptr};
    assign src_w    = (wp_w >= off_w) ? (wp_w - off_w)
                                      : (wp_w + (AW+1)'(HISTORY_DEPTH) - off_w);
    assign src      = src_w[AW-1:0];
    assign wptr_inc = (r_wptr == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_lit      = r_lit;
        n_ml       = r_ml;
        n_mb       = r_mb;
        n_off      = r_off;
        n_oc       = r_oc;
        n_lms      = r_lms;
        n_llr      = r_llr;
        n_fin      = r_fin;
        n_first    = r_first;
        n_end      = r_end;
        n_wptr     = r_wptr;
        v_fin      = 1'b0;
        v_code     = ST_OK;
        v_st       = ST_OK;
        v_emit     = 1'b0;
        v_from_mem = 1'b0;

        if (cmd == CMD_START) begin
            // A new block restarts parsing; the history contents stay.
            n_phase = PH_TOKEN;
            n_lit   = '0;
            n_ml    = '0;
            n_mb    = '0;
            n_off   = '0;
            n_oc    = '0;
            n_lms   = '0;
            n_llr   = '0;
            n_fin   = 1'b0;
            n_first = 1'b0;
            n_end   = ST_OK;
            n_wptr  = '0;
        end else if (cmd == CMD_NONE) begin
            v_st = r_fin ? r_end : ST_OK;
        end else if (r_fin) begin
            v_st = r_end;
        end else if (cmd == CMD_PULL) begin
            // One copied byte per pull; the RAM or forwarding register gives it next cycle.
            if (r_ml != '0) begin
                v_emit     = 1'b1;
                v_from_mem = 1'b1;
                n_oc       = r_oc + 1'b1;
                n_wptr     = wptr_inc;
                n_ml       = r_ml - 1'b1;
            end
        end else if (r_ml != '0) begin
            // Compressed bytes get a busy status until the queued copy has been pulled out.
            v_st = ST_BUSY;
        end else begin
            case (r_phase)
                PH_TOKEN: begin
                    n_first = 1'b1;
                    if (!r_first && b == 8'h00) begin
                        v_fin  = 1'b1;
                        v_code = ST_EMPTY;
                    end else begin
                        n_mb  = t_cnt'(b[3:0]) + t_cnt'(MIN_MATCH);
                        n_lit = t_cnt'(b[7:4]);
                        n_llr = t_cnt'(b[7:4]);
                        if (b[7:4] == LIT_EXT) begin
                            n_phase = PH_LITEXT;
                            if (last) begin
                                v_fin  = 1'b1;
                                v_code = ST_TRUNC;
                            end
                        end else if (!fits) begin
                            v_fin  = 1'b1;
                            v_code = ST_OVERFLOW;
                        end else if (b[7:4] != 4'h0) begin
                            n_phase = PH_LIT;
                            if (last) begin
                                v_fin  = 1'b1;
                                v_code = ST_TRUNC;
                            end
                        end else if (!last) begin
                            n_phase = PH_OFFLO;
                        end else begin
                            // No literals in this sequence, so the last run is empty.
                            v_fin  = 1'b1;
                            v_code = f_end_code(r_oc, '0, r_lms);
                        end
                    end
                end
                PH_LITEXT: begin
                    n_lit = fit_arg[SB-1:0];
                    n_llr = fit_arg[SB-1:0];
                    if (!fits) begin
                        v_fin  = 1'b1;
                        v_code = ST_OVERFLOW;
                    end else begin
                        if (b != EXT_MORE) begin
                            n_phase = PH_LIT;
                        end
                        if (last) begin
                            v_fin  = 1'b1;
                            v_code = ST_TRUNC;
                        end
                    end
                end
                PH_LIT: begin
                    v_emit = 1'b1;
                    n_oc   = r_oc + 1'b1;
                    n_wptr = wptr_inc;
                    n_lit  = r_lit - 1'b1;
                    if (n_lit == '0) begin
                        if (!last) begin
                            n_phase = PH_OFFLO;
                        end else begin
                            v_fin  = 1'b1;
                            v_code = f_end_code(n_oc, r_llr, r_lms);
                        end
                    end else if (last) begin
                        v_fin  = 1'b1;
                        v_code = ST_TRUNC;
                    end
                end
                PH_OFFLO: begin
                    n_off   = {8'h00, b};
                    n_phase = PH_OFFHI;
                    if (last) begin
                        v_fin  = 1'b1;
                        v_code = ST_TRUNC;
                    end
                end
                PH_OFFHI: begin
                    n_off = off_new;
                    if (bad_off) begin
                        v_fin  = 1'b1;
                        v_code = ST_BAD_OFF;
                    end else if (r_mb == t_cnt'(MATCH_EXT_LEN)) begin
                        n_phase = PH_MEXT;
                        if (last) begin
                            v_fin  = 1'b1;
                            v_code = ST_TRUNC;
                        end
                    end else if (last) begin
                        // A block may not end on a match.
                        v_fin  = 1'b1;
                        v_code = ST_END_RULE;
                    end else if (!fits) begin
                        v_fin  = 1'b1;
                        v_code = ST_OVERFLOW;
                    end else begin
                        n_ml    = r_mb;
                        n_lms   = r_oc;
                        n_phase = PH_TOKEN;
                    end
                end
                default: begin
                    // Extended match length bytes.
                    n_mb = fit_arg[SB-1:0];
                    if (!fits) begin
                        v_fin  = 1'b1;
                        v_code = ST_OVERFLOW;
                    end else if (b == EXT_MORE) begin
                        if (last) begin
                            v_fin  = 1'b1;
                            v_code = ST_TRUNC;
                        end
                    end else if (last) begin
                        v_fin  = 1'b1;
                        v_code = ST_END_RULE;
                    end else begin
                        n_ml    = fit_arg[SB-1:0];
                        n_lms   = r_oc;
                        n_phase = PH_TOKEN;
                    end
                end
            endcase
        end

        if (v_fin) begin
            n_fin = 1'b1;
            n_end = v_code;
            n_lit = '0;
            n_ml  = '0;
            v_st  = v_code;
        end
    end

    // Second-stage contents. A pull that reads the entry written in this very
    // cycle takes the byte from the forwarding register instead of the RAM.
    always_comb begin
        n_s1.status       = v_st;
        n_s1.out_valid    = v_emit;
        n_s1.lit_byte     = b;
        n_s1.from_mem     = v_from_mem;
        n_s1.fwd          = v_from_mem && ram_we && (src == r_s1.wr_addr);
        n_s1.total_size   = TOTAL_W'(n_oc);
        n_s1.copy_pending = (n_ml != '0);
        n_s1.wr_addr      = r_wptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TOKEN;
            r_lit      <= '0;
            r_ml       <= '0;
            r_mb       <= '0;
            r_off      <= '0;
            r_oc       <= '0;
            r_lms      <= '0;
            r_llr      <= '0;
            r_fin      <= 1'b0;
            r_first    <= 1'b0;
            r_end      <= ST_OK;
            r_wptr     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_phase <= n_phase;
                r_lit   <= n_lit;
                r_ml    <= n_ml;
                r_mb    <= n_mb;
                r_off   <= n_off;
                r_oc    <= n_oc;
                r_lms   <= n_lms;
                r_llr   <= n_llr;
                r_fin   <= n_fin;
                r_first <= n_first;
                r_end   <= n_end;
                r_wptr  <= n_wptr;
            end
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_s1;
        end
        r_fwd_data <= s1_byte;
    end

    // Resolve the output byte: a literal, a RAM read, or the byte written last cycle.
    always_comb begin
        if (!r_s1.out_valid) begin
            s1_byte = 8'h00;
        end else if (r_s1.from_mem) begin
            s1_byte = r_s1.fwd ? r_fwd_data : ram_rdata;
        end else begin
            s1_byte = r_s1.lit_byte;
        end
    end

    assign ram_we = r_s1_valid && r_s1.out_valid;

    lz4d_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1.wr_addr),
        .i_wdata (s1_byte),
        .i_re    (acc && v_from_mem),
        .i_raddr (src),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        push_item.out_byte     = s1_byte;
        push_item.out_valid    = r_s1.out_valid;
        push_item.status       = r_s1.status;
        push_item.total_size   = r_s1.total_size;
        push_item.copy_pending = r_s1.copy_pending;
    end

    lz4d_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_item (push_item),
        .o_level     (fifo_level),
        .o_res       (o_res)
    );

    // A finished block never holds queued literals or a pending copy.
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> (r_ml == '0 && r_lit == '0))
        else $error("finished block still holds pending lengths");

    // The last match start never lies beyond the bytes produced.
    a_lms_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lms <= r_oc)
        else $error("last match start beyond output count");

    // A start beat returns the parser to an empty, open block.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && cmd == CMD_START) |=> (r_oc == '0 && !r_fin && r_phase == PH_TOKEN))
        else $error("start beat did not clear the block");
endmodule
